// ===== rtl/core/sem_pkg.sv =====
// ----------------------------------------------------------------------------
// sem_pkg: shared types and constants for the Sobel edge magnitude stream
// Widths, line store geometry, register codes and the structs passed
// between the front end, the item queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

   // Line store geometry
   localparam int LINE_DEPTH = 2048;
   localparam int COL_W      = $clog2(LINE_DEPTH);
   localparam int MAX_ROWS   = 4096;
   localparam int ROW_W      = 12;

   // Field and register widths
   localparam int PIX_W      = 8;
   localparam int ROWS_REG_W = 13;
   localparam int COLS_REG_W = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   // Register reset values
   localparam logic [ROWS_REG_W-1:0] ROWS_RESET = ROWS_REG_W'(480);
   localparam logic [COLS_REG_W-1:0] COLS_RESET = COLS_REG_W'(640);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ROWS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COLS = CSR_IDX_W'(1);

   // Item queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Datapath widths
   localparam int LS_W    = 2 * PIX_W;  // both line stores in one word
   localparam int SUM_W   = PIX_W + 2;  // one side of a gradient
   localparam int GRAD_W  = SUM_W + 1;  // signed gradient
   localparam int SQ_W    = 2 * SUM_W;  // square of a gradient
   localparam int RAD_W   = SQ_W + 1;   // sum of squares
   localparam int ROOT_W  = PIX_W;      // root before saturation
   localparam int RADLO_W = 2 * ROOT_W; // radicand part the root unit sees
   localparam int REM_W   = ROOT_W + 2;
   localparam int STEP_W  = $clog2(ROOT_W);

   typedef struct packed {
      logic [ROWS_REG_W-1:0] rows;
      logic [COLS_REG_W-1:0] cols;
   } sem_cfg_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [COL_W-1:0] col;
      logic             frame_end;
   } sem_item_type;

   typedef struct packed {
      logic [PIX_W-1:0] edge_magnitude;
      logic             frame_end;
   } sem_result_type;

endpackage

`default_nettype wire

// ===== rtl/core/sem_ram.sv =====
// ----------------------------------------------------------------------------
// sem_ram: generic single write port, single read port RAM
// Read data is registered; no reset on the array or the read register.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sem_front.sv =====
// ----------------------------------------------------------------------------
// sem_front: input front end
// Accepts pixels, tracks row and column position, tags each pixel with
// its line store column and the end-of-frame flag, and pushes it to the
// item queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sem_pkg::sem_cfg_type      cfg,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [sem_pkg::PIX_W-1:0] req_pixel,
   input  wire logic                      queue_full,
   input  wire logic                      clear_busy,
   output logic                           push,
   output sem_pkg::sem_item_type          item
);

   import sem_pkg::*;

   logic [ROWS_REG_W-1:0] rows_eff;
   logic [COLS_REG_W:0]   cols_eff;
   logic [ROW_W-1:0]      last_row;
   logic [COL_W-1:0]      last_col;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic                  row_end;
   logic                  row_last;

   // Frame geometry with out-of-range sizes clamped
   always_comb begin
      priority if (cfg.rows == '0) begin
         rows_eff = ROWS_REG_W'(1);
      end else if (cfg.rows > ROWS_REG_W'(MAX_ROWS)) begin
         rows_eff = ROWS_REG_W'(MAX_ROWS);
      end else begin
         rows_eff = cfg.rows;
      end
      priority if (cfg.cols == '0) begin
         cols_eff = (COLS_REG_W+1)'(1);
      end else if ({1'b0, cfg.cols} > (COLS_REG_W+1)'(LINE_DEPTH)) begin
         cols_eff = (COLS_REG_W+1)'(LINE_DEPTH);
      end else begin
         cols_eff = {1'b0, cfg.cols};
      end
   end

   assign last_row = ROW_W'(rows_eff - 1'b1);
   assign last_col = COL_W'(cols_eff - 1'b1);

   // Accept while the queue has room and the line store sweep is done
   assign req_stall = queue_full || clear_busy;
   assign push      = req_valid && !req_stall;

   assign row_end  = (col_ff >= last_col);
   assign row_last = (row_ff >= last_row);

   assign item.pixel     = req_pixel;
   assign item.col       = col_ff;
   assign item.frame_end = row_end && row_last;

   // Raster position
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (push) begin
         if (row_end) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/sem_fifo.sv =====
// ----------------------------------------------------------------------------
// sem_fifo: short item queue
// Decouples the front end from the back end; registers only.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire sem_pkg::sem_item_type push_item,
   input  wire logic                  pop,
   output sem_pkg::sem_item_type      head,
   output logic                       empty,
   output logic                       full
);

   import sem_pkg::*;

   sem_item_type       entry_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == QCNT_W'(QDEPTH));
   assign head  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/sem_back.sv =====
// ----------------------------------------------------------------------------
// sem_back: processing back end
// Clears the line store after reset, then per item: line store
// read-modify-write, window shift, Sobel gradients, squares and an
// iterative integer square root (one result bit per cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module sem_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sem_pkg::sem_item_type head,
   input  wire logic                  empty,
   output logic                       pop,
   output logic                       clear_busy,
   input  wire logic                  out_free,
   output logic                       res_load,
   output sem_pkg::sem_result_type    res
);

   import sem_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_GRAD  = 3'd3;
   localparam logic [2:0] ST_SQX   = 3'd4;
   localparam logic [2:0] ST_SQY   = 3'd5;
   localparam logic [2:0] ST_ROOT  = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   logic [2:0]               state_ff, state_in;
   logic [COL_W-1:0]         clr_addr_ff;
   sem_item_type             cur_ff;
   logic [PIX_W-1:0]         win_ff [3][3];

   logic                     ram_wr_en;
   logic [COL_W-1:0]         ram_wr_addr;
   logic [LS_W-1:0]          ram_wr_data;
   logic [LS_W-1:0]          ram_rd_data;

   logic [SUM_W-1:0]         gx_pos, gx_neg, gy_pos, gy_neg;
   logic signed [GRAD_W-1:0] gx_ff, gy_ff;
   logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
   logic [SQ_W-1:0]          sqx_ff;
   logic [RAD_W-1:0]         rad_sum;

   logic [RADLO_W-1:0]       rad_ff;
   logic                     sat_ff;
   logic [REM_W-1:0]         rem_ff;
   logic [ROOT_W-1:0]        root_ff;
   logic [STEP_W-1:0]        step_ff;
   logic [REM_W+1:0]         rem_sh;
   logic [REM_W+1:0]         trial;
   logic                     take_bit;

   assign clear_busy = (state_ff == ST_CLEAR);
   assign pop        = (state_ff == ST_IDLE) && !empty;
   assign res_load   = (state_ff == ST_OUT) && out_free;

   assign res.edge_magnitude = sat_ff ? '1 : root_ff;
   assign res.frame_end      = cur_ff.frame_end;

   // Line store: low byte is the upper line, high byte the middle line
   always_comb begin
      ram_wr_en   = clear_busy || (state_ff == ST_LOAD);
      ram_wr_addr = clear_busy ? clr_addr_ff : cur_ff.col;
      ram_wr_data = clear_busy ? '0 : {cur_ff.pixel, ram_rd_data[LS_W-1:PIX_W]};
   end

   sem_ram #(
      .WIDTH (LS_W),
      .DEPTH (LINE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (pop),
      .rd_addr (head.col),
      .rd_data (ram_rd_data)
   );

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == COL_W'(LINE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!empty) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: state_in = ST_GRAD;
         ST_GRAD: state_in = ST_SQX;
         ST_SQX:  state_in = ST_SQY;
         ST_SQY:  state_in = ST_ROOT;
         ST_ROOT: begin
            if (step_ff == STEP_W'(ROOT_W - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (clear_busy) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   // Window: shift left, new right column from line store and pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (state_ff == ST_LOAD) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= ram_rd_data[PIX_W-1:0];
         win_ff[1][2] <= ram_rd_data[LS_W-1:PIX_W];
         win_ff[2][2] <= cur_ff.pixel;
      end
   end

   // Gradients: positive and negative taps summed apart
   always_comb begin
      gx_pos = {2'b00, win_ff[0][0]} + {1'b0, win_ff[1][0], 1'b0} + {2'b00, win_ff[2][0]};
      gx_neg = {2'b00, win_ff[0][2]} + {1'b0, win_ff[1][2], 1'b0} + {2'b00, win_ff[2][2]};
      gy_pos = {2'b00, win_ff[0][0]} + {1'b0, win_ff[0][1], 1'b0} + {2'b00, win_ff[0][2]};
      gy_neg = {2'b00, win_ff[2][0]} + {1'b0, win_ff[2][1], 1'b0} + {2'b00, win_ff[2][2]};
   end

   assign gx_sq   = gx_ff * gx_ff;
   assign gy_sq   = gy_ff * gy_ff;
   assign rad_sum = {1'b0, sqx_ff} + {1'b0, gy_sq[SQ_W-1:0]};

   // Root step: bring down two radicand bits, try the next result bit
   assign rem_sh   = {rem_ff, rad_ff[RADLO_W-1 -: 2]};
   assign trial    = {2'b00, root_ff, 2'b01};
   assign take_bit = (rem_sh >= trial);

   // Item datapath
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head;
      end
      if (state_ff == ST_GRAD) begin
         gx_ff <= $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
         gy_ff <= $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
      end
      if (state_ff == ST_SQX) begin
         sqx_ff <= gx_sq[SQ_W-1:0];
      end
      if (state_ff == ST_SQY) begin
         // a radicand of 2^16 or more saturates the result
         sat_ff  <= |rad_sum[RAD_W-1:RADLO_W];
         rad_ff  <= rad_sum[RADLO_W-1:0];
         rem_ff  <= '0;
         root_ff <= '0;
         step_ff <= '0;
      end
      if (state_ff == ST_ROOT) begin
         rad_ff  <= {rad_ff[RADLO_W-3:0], 2'b00};
         step_ff <= step_ff + 1'b1;
         if (take_bit) begin
            rem_ff  <= REM_W'(rem_sh - trial);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh[REM_W-1:0];
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/sobel_edge_magnitude_stream.sv =====
// A pixel goes through the item queue, the back end and the output register to rsp_valid.
// The back end takes one pixel at a time through its sequence
//   (line store read-modify-write, gradients, two squares, 8-step square root).
// A queue of two items and an output register let both sides stall on their own.
// Reset: synchronous; clears counters, window and registers (480 rows, 640 cols),
//   then sweeps all 2048 line store entries to zero with req_stall high.
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_stream: 3x3 Sobel edge magnitude over a pixel stream
// Raster pixels in, floor(sqrt(Gx^2+Gy^2)) saturated to 255 out, with an
// end-of-frame flag on the last pixel of each frame.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_magnitude_stream (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // pixel input
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [sem_pkg::PIX_W-1:0]      req_pixel,
   // result output
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [sem_pkg::PIX_W-1:0]           rsp_edge_magnitude,
   output logic                                rsp_frame_end,
   // register writes
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [sem_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sem_pkg::CSR_DATA_W-1:0] csr_data
);

   import sem_pkg::*;

   sem_cfg_type    cfg_ff;
   sem_item_type   push_item;
   sem_item_type   head;
   sem_result_type res;
   logic           push;
   logic           pop;
   logic           q_empty;
   logic           q_full;
   logic           clear_busy;
   logic           out_free;
   logic           res_load;
   logic           rsp_valid_ff;
   sem_result_type rsp_ff;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rows <= ROWS_RESET;
         cfg_ff.cols <= COLS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_ROWS: cfg_ff.rows <= csr_data[ROWS_REG_W-1:0];
            CSR_FRAME_COLS: cfg_ff.cols <= csr_data[COLS_REG_W-1:0];
            default: ;
         endcase
      end
   end

   sem_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_pixel  (req_pixel),
      .queue_full (q_full),
      .clear_busy (clear_busy),
      .push       (push),
      .item       (push_item)
   );

   sem_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   sem_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (q_empty),
      .pop        (pop),
      .clear_busy (clear_busy),
      .out_free   (out_free),
      .res_load   (res_load),
      .res        (res)
   );

   // Output register: free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_edge_magnitude = rsp_ff.edge_magnitude;
   assign rsp_frame_end      = rsp_ff.frame_end;

endmodule

`default_nettype wire

// ===== rtl/core/sem_checker.sv =====
// ----------------------------------------------------------------------------
// sem_checker: port-level checks for the Sobel edge magnitude stream
// Tracks transfers in flight and checks ordering and capacity at the ports.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_stall,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [sem_pkg::PIX_W-1:0]      rsp_edge_magnitude,
   input wire logic                           rsp_frame_end
);

   import sem_pkg::*;

   logic       in_xfer;
   logic       out_xfer;
   logic [3:0] pending_ff;

   assign in_xfer  = req_valid && !req_stall;
   assign out_xfer = rsp_valid && !rsp_stall;

   // Items taken in and not yet delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + {3'b000, in_xfer} - {3'b000, out_xfer};
      end
   end

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_edge_magnitude)
                                 && $stable(rsp_frame_end))
      else $error("result changed while stalled");

   // No result without an earlier input transfer
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 4'd0)
      else $error("result with no pixel in flight");

   // An input into an empty block cannot come out on the next cycle
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 4'd0 && in_xfer |=> !rsp_valid)
      else $error("result too early");

   // Queue, back end and output register hold four items at most
   a_capacity: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 4'd4 |-> req_stall)
      else $error("input taken beyond capacity");

   // Line store sweep holds off input right after reset
   a_clear_stall: assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("input open during line store clear");

endmodule

bind sobel_edge_magnitude_stream sem_checker u_sem_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_edge_magnitude (rsp_edge_magnitude),
   .rsp_frame_end      (rsp_frame_end)
);

`default_nettype wire
